// ----- hw/rtl/subscription_interval_matcher_assert.svh -----
// Assertion macros for the subscription interval matcher.
`ifndef SUBSCRIPTION_INTERVAL_MATCHER_ASSERT_SVH
`define SUBSCRIPTION_INTERVAL_MATCHER_ASSERT_SVH

// Checks that cons holds in the same cycle as ante.
`define SIM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("subscription_interval_matcher: check failed");

// Checks that cons holds in the cycle after ante.
`define SIM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("subscription_interval_matcher: check failed");

`endif

// ----- hw/rtl/sim_pkg.sv -----
// Package with word types, command codes and control structs of the matcher.
`timescale 1ns / 1ps
package sim_pkg;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_EVENT = 2'd2;
    localparam logic [1:0] CMD_EVAL  = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic [5:0]         subscription_index;
        logic [3:0]         attribute_id;
        logic signed [31:0] attribute_value;
        logic signed [31:0] interval_low;
        logic signed [31:0] interval_high;
    } t_in_word;

    typedef struct packed {
        logic [5:0] subscription_id;
        logic       matched;
        logic       last;
        logic       status;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic sel_s_in;
        logic sel_a_in;
        logic cnt_clr;
        logic add_wr;
        logic ev_wr;
        logic ev_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic       s_ok;
        logic       a_ok;
        logic       cnt_zero;
        logic       full;
        logic       hit;
    } t_dp_stat;

endpackage

// ----- hw/rtl/sim_datapath.sv -----
// Datapath of the matcher: interval tables, event store and interval compare.
`timescale 1ns / 1ps
module sim_datapath
    import sim_pkg::*;
#(
    parameter int SUBSCRIPTIONS = 64,
    parameter int ATTRIBUTES    = 16,
    parameter int INTERVALS     = 4,
    parameter int SW            = 6,
    parameter int AW            = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_cmd,
    input  t_in_word      i_word,
    input  logic [SW-1:0] i_s,
    input  logic [AW-1:0] i_a,
    output t_dp_stat      o_stat
);

    localparam int CW    = $clog2(INTERVALS + 1);
    localparam int DEPTH = 1 << (SW + AW);
    localparam int EA    = 1 << AW;
    localparam int SXW   = (SW > 6) ? SW : 6;
    localparam int AXW   = (AW > 4) ? AW : 4;

    t_in_word r_word;
    logic [CW-1:0] r_cnt_mem [DEPTH];
    logic [INTERVALS*64-1:0] r_bnd_mem [DEPTH];
    logic signed [31:0] r_ev_mem [EA];
    logic [EA-1:0] r_present;
    logic [CW-1:0] r_cnt_q;
    logic [INTERVALS*64-1:0] r_bnd_q;
    logic signed [31:0] r_ev_q;
    logic r_pres_q;

    logic [SXW-1:0] w_s_ext;
    logic [AXW-1:0] w_a_ext;
    logic [SW-1:0] w_s;
    logic [AW-1:0] w_a;
    logic [SW+AW-1:0] w_addr;
    logic w_s_ok;
    logic w_a_ok;
    logic w_full;
    logic w_any;

    assign w_s_ext = SXW'(r_word.subscription_index);
    assign w_a_ext = AXW'(r_word.attribute_id);
    assign w_s_ok = 32'(r_word.subscription_index) < 32'(SUBSCRIPTIONS);
    assign w_a_ok = 32'(r_word.attribute_id) < 32'(ATTRIBUTES);
    assign w_s = i_cmd.sel_s_in ? w_s_ext[SW-1:0] : i_s;
    assign w_a = i_cmd.sel_a_in ? w_a_ext[AW-1:0] : i_a;
    assign w_addr = {w_s, w_a};
    assign w_full = r_cnt_q >= CW'(INTERVALS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_clr) begin
            r_cnt_mem[w_addr] <= '0;
        end else if (i_cmd.add_wr && !w_full) begin
            r_cnt_mem[w_addr] <= r_cnt_q + CW'(1);
        end
        r_cnt_q <= r_cnt_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < INTERVALS; j++) begin
            if (i_cmd.add_wr && !w_full && r_cnt_q == CW'(j)) begin
                r_bnd_mem[w_addr][j*64 +: 64] <= {r_word.interval_low, r_word.interval_high};
            end
        end
        r_bnd_q <= r_bnd_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ev_wr && w_a_ok && !r_present[w_a]) begin
            r_ev_mem[w_a] <= r_word.attribute_value;
        end
        r_ev_q <= r_ev_mem[w_a];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.ev_clr) begin
            r_present <= '0;
        end else if (i_cmd.ev_wr && w_a_ok) begin
            r_present[w_a] <= 1'b1;
        end
        r_pres_q <= r_present[w_a];
    end

    always_comb begin
        w_any = 1'b0;
        for (int j = 0; j < INTERVALS; j++) begin
            if (CW'(j) < r_cnt_q
                    && $signed(r_bnd_q[j*64+32 +: 32]) <= r_ev_q
                    && $signed(r_bnd_q[j*64 +: 32]) >= r_ev_q) begin
                w_any = 1'b1;
            end
        end
    end

    assign o_stat.command  = r_word.command;
    assign o_stat.s_ok     = w_s_ok;
    assign o_stat.a_ok     = w_a_ok;
    assign o_stat.cnt_zero = r_cnt_q == '0;
    assign o_stat.full     = w_full;
    assign o_stat.hit      = r_pres_q && w_any;

endmodule

// ----- hw/rtl/sim_ctrl.sv -----
// Controller of the matcher: command sequencing, table sweeps and result words.
`timescale 1ns / 1ps
module sim_ctrl
    import sim_pkg::*;
#(
    parameter int SUBSCRIPTIONS = 64,
    parameter int ATTRIBUTES    = 16,
    parameter int SW            = 6,
    parameter int AW            = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_dp_stat      i_stat,
    output t_dp_cmd       o_cmd,
    output logic [SW-1:0] o_s,
    output logic [AW-1:0] o_a,
    output logic          o_busy,
    output logic          o_strobe,
    output t_out_word     o_word
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DEC, S_ADD_RD, S_ADD_WR, S_CLR, S_RD, S_CHK, S_FIN
    } t_state;

    t_state r_state;
    logic [SW-1:0] r_s;
    logic [AW-1:0] r_a;
    logic r_busy;
    logic r_strobe;
    t_out_word r_out;
    logic r_cons;
    logic r_pend;
    logic [SW-1:0] r_pend_id;

    logic w_last_a;
    logic w_last_s;
    logic w_fail;
    logic w_cons;

    assign w_last_a = r_a == AW'(ATTRIBUTES - 1);
    assign w_last_s = r_s == SW'(SUBSCRIPTIONS - 1);
    assign w_fail = !i_stat.cnt_zero && !i_stat.hit;
    assign w_cons = r_cons || !i_stat.cnt_zero;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_INIT: o_cmd.cnt_clr = 1'b1;
            S_IDLE: o_cmd.load = i_start;
            S_DEC: begin
                o_cmd.sel_s_in = 1'b1;
                o_cmd.sel_a_in = 1'b1;
                o_cmd.ev_wr = i_stat.command == CMD_EVENT;
            end
            S_ADD_RD: begin
                o_cmd.sel_s_in = 1'b1;
                o_cmd.sel_a_in = 1'b1;
            end
            S_ADD_WR: begin
                o_cmd.sel_s_in = 1'b1;
                o_cmd.sel_a_in = 1'b1;
                o_cmd.add_wr = 1'b1;
            end
            S_CLR: begin
                o_cmd.sel_s_in = 1'b1;
                o_cmd.cnt_clr = 1'b1;
            end
            S_FIN: o_cmd.ev_clr = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_s <= '0;
            r_a <= '0;
            r_busy <= 1'b1;
            r_strobe <= 1'b0;
            r_cons <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_INIT: begin
                    r_a <= w_last_a ? '0 : r_a + AW'(1);
                    if (w_last_a) begin
                        r_s <= r_s + SW'(1);
                        if (w_last_s) begin
                            r_s <= '0;
                            r_busy <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_busy <= 1'b1;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_s <= '0;
                    r_a <= '0;
                    r_cons <= 1'b0;
                    r_pend <= 1'b0;
                    r_out <= '{subscription_id: '0, matched: 1'b0, last: 1'b1, status: 1'b0};
                    case (i_stat.command)
                        CMD_ADD: begin
                            if (i_stat.s_ok && i_stat.a_ok) begin
                                r_state <= S_ADD_RD;
                            end else begin
                                r_strobe <= 1'b1;
                                r_busy <= 1'b0;
                                r_state <= S_IDLE;
                            end
                        end
                        CMD_CLEAR: begin
                            if (i_stat.s_ok) begin
                                r_state <= S_CLR;
                            end else begin
                                r_strobe <= 1'b1;
                                r_busy <= 1'b0;
                                r_state <= S_IDLE;
                            end
                        end
                        CMD_EVAL: r_state <= S_RD;
                        default: begin
                            r_strobe <= 1'b1;
                            r_busy <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_ADD_RD: r_state <= S_ADD_WR;
                S_ADD_WR: begin
                    r_out.status <= i_stat.full;
                    r_strobe <= 1'b1;
                    r_busy <= 1'b0;
                    r_state <= S_IDLE;
                end
                S_CLR: begin
                    r_a <= r_a + AW'(1);
                    if (w_last_a) begin
                        r_strobe <= 1'b1;
                        r_busy <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    if (w_fail || w_last_a) begin
                        if (!w_fail && w_cons) begin
                            if (r_pend) begin
                                r_out <= '{subscription_id: 6'(r_pend_id), matched: 1'b1,
                                           last: 1'b0, status: 1'b0};
                                r_strobe <= 1'b1;
                            end
                            r_pend <= 1'b1;
                            r_pend_id <= r_s;
                        end
                        r_a <= '0;
                        r_cons <= 1'b0;
                        r_s <= r_s + SW'(1);
                        r_state <= w_last_s ? S_FIN : S_RD;
                    end else begin
                        r_a <= r_a + AW'(1);
                        r_cons <= w_cons;
                        r_state <= S_RD;
                    end
                end
                S_FIN: begin
                    r_out <= '{subscription_id: r_pend ? 6'(r_pend_id) : 6'd0,
                               matched: r_pend, last: 1'b1, status: 1'b0};
                    r_strobe <= 1'b1;
                    r_busy <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s = r_s;
    assign o_a = r_a;
    assign o_busy = r_busy;
    assign o_strobe = r_strobe;
    assign o_word = r_out;

endmodule

// ----- hw/rtl/subscription_interval_matcher.sv -----
// Top level of the subscription interval matcher.
//
//   channel  | ports                 | handshake
//   ---------+-----------------------+---------------------------------
//   command  | i_word                | taken when start high, busy low
//   result   | o_word                | one cycle, marked by o_strobe
//
// Add reads the count table and then writes the interval; clear sweeps every attribute of
// the subscription; event and out-of-range add or clear answer from the decode state.
// Evaluate visits each subscription and its attributes in turn, with each table read
// registered; a subscription stops at its first failing attribute.
// After reset a pass clears the count table with busy high.
// A match is held until the next match or the end of the sweep so that last can be set.
// The receiver cannot stall.
`timescale 1ns / 1ps
`include "subscription_interval_matcher_assert.svh"
module subscription_interval_matcher
    import sim_pkg::*;
#(
    parameter int SUBSCRIPTIONS = 64,
    parameter int ATTRIBUTES    = 16,
    parameter int INTERVALS     = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_word,
    output logic      o_strobe,
    output t_out_word o_word
);

    localparam int SW = $clog2(SUBSCRIPTIONS);
    localparam int AW = (ATTRIBUTES > 1) ? $clog2(ATTRIBUTES) : 1;

    t_dp_cmd w_cmd;
    t_dp_stat w_stat;
    logic [SW-1:0] w_s;
    logic [AW-1:0] w_a;

    sim_ctrl #(
        .SUBSCRIPTIONS(SUBSCRIPTIONS), .ATTRIBUTES(ATTRIBUTES), .SW(SW), .AW(AW)
    ) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_stat(w_stat),
        .o_cmd(w_cmd), .o_s(w_s), .o_a(w_a), .o_busy(busy),
        .o_strobe(o_strobe), .o_word(o_word)
    );

    sim_datapath #(
        .SUBSCRIPTIONS(SUBSCRIPTIONS), .ATTRIBUTES(ATTRIBUTES), .INTERVALS(INTERVALS),
        .SW(SW), .AW(AW)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_word(i_word),
        .i_s(w_s), .i_a(w_a), .o_stat(w_stat)
    );

    `SIM_ASSERT_NOW(a_strobe_busy, o_strobe, $past(busy))
    `SIM_ASSERT_NEXT(a_accept_quiet, start && !busy, !o_strobe)
    `SIM_ASSERT_NOW(a_nomatch_zero, o_strobe && !o_word.matched, o_word.subscription_id == 6'd0)
    `SIM_ASSERT_NOW(a_last_frees, o_strobe, o_word.last == !busy)

endmodule

// ----- bench/tb_top.sv -----
// Testbench for the subscription interval matcher: directed and random commands checked
// against a behavioral prediction of the subscription table and the event store.
`timescale 1ns / 1ps
module tb_top;
    import sim_pkg::*;

    localparam int NSUB  = 64;
    localparam int NATTR = 16;
    localparam int NINT  = 4;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_word  i_word = '0;
    logic      o_strobe;
    t_out_word o_word;

    subscription_interval_matcher #(
        .SUBSCRIPTIONS(NSUB),
        .ATTRIBUTES(NATTR),
        .INTERVALS(NINT)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_word(i_word),
        .o_strobe(o_strobe),
        .o_word(o_word)
    );

    always #6 i_clk = ~i_clk;

    int unsigned       sub_count [NSUB][NATTR];
    logic signed [31:0] sub_lo [NSUB][NATTR][NINT];
    logic signed [31:0] sub_hi [NSUB][NATTR][NINT];
    logic              ev_have [NATTR];
    logic signed [31:0] ev_val [NATTR];
    t_out_word         pending_words [$];
    int                fail_count = 0;
    bit                idle_on = 1'b1;

    function automatic bit sub_hits(int s);
        bit constrained;
        bit hit;
        constrained = 1'b0;
        for (int a = 0; a < NATTR; a++) begin
            if (sub_count[s][a] == 0) continue;
            constrained = 1'b1;
            if (!ev_have[a]) return 1'b0;
            hit = 1'b0;
            for (int i = 0; i < sub_count[s][a]; i++) begin
                if (sub_lo[s][a][i] <= ev_val[a] && sub_hi[s][a][i] >= ev_val[a]) hit = 1'b1;
            end
            if (!hit) return 1'b0;
        end
        return constrained;
    endfunction

    task automatic queue_word(t_out_word r);
        pending_words.insert(pending_words.size(), r);
    endtask

    task automatic predict_words(t_in_word w);
        t_out_word r;
        int        n;
        r = '0;
        r.last = 1'b1;
        case (w.command)
            CMD_ADD: begin
                n = sub_count[w.subscription_index][w.attribute_id];
                if (n >= NINT) begin
                    r.status = 1'b1;
                end else begin
                    sub_lo[w.subscription_index][w.attribute_id][n] = w.interval_low;
                    sub_hi[w.subscription_index][w.attribute_id][n] = w.interval_high;
                    sub_count[w.subscription_index][w.attribute_id] = n + 1;
                end
                queue_word(r);
            end
            CMD_CLEAR: begin
                for (int a = 0; a < NATTR; a++) sub_count[w.subscription_index][a] = 0;
                queue_word(r);
            end
            CMD_EVENT: begin
                if (!ev_have[w.attribute_id]) begin
                    ev_have[w.attribute_id] = 1'b1;
                    ev_val[w.attribute_id] = w.attribute_value;
                end
                queue_word(r);
            end
            default: begin
                n = 0;
                for (int s = 0; s < NSUB; s++) begin
                    if (sub_hits(s)) begin
                        r = '0;
                        r.subscription_id = 6'(s);
                        r.matched = 1'b1;
                        queue_word(r);
                        n++;
                    end
                end
                if (n == 0) begin
                    r = '0;
                    r.last = 1'b1;
                    queue_word(r);
                end else begin
                    pending_words[pending_words.size() - 1].last = 1'b1;
                end
                for (int a = 0; a < NATTR; a++) ev_have[a] = 1'b0;
            end
        endcase
    endtask

    task automatic send_word(t_in_word w);
        @(negedge i_clk);
        if (idle_on) begin
            while ($urandom_range(99) < 37) begin
                start <= 1'b0;
                @(negedge i_clk);
            end
        end
        start <= 1'b1;
        i_word <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_words(w);
    endtask

    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_strobe) begin
            if (pending_words.size() == 0) begin
                $error("unexpected word: id %0d matched %0d", o_word.subscription_id,
                       o_word.matched);
                fail_count++;
            end else begin
                e = pending_words.pop_front();
                if (o_word.subscription_id !== e.subscription_id) begin
                    $error("subscription_id: expected %0d, got %0d", e.subscription_id,
                           o_word.subscription_id);
                    fail_count++;
                end
                if (o_word.matched !== e.matched) begin
                    $error("matched: expected %0d, got %0d", e.matched, o_word.matched);
                    fail_count++;
                end
                if (o_word.last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, o_word.last);
                    fail_count++;
                end
                if (o_word.status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_word.status);
                    fail_count++;
                end
            end
        end
    end

    function automatic t_in_word make_word(logic [1:0] c, int s, int a,
                                           logic [31:0] v, logic [31:0] lo, logic [31:0] hi);
        t_in_word w;
        w.command = c;
        w.subscription_index = 6'(s);
        w.attribute_id = 4'(a);
        w.attribute_value = v;
        w.interval_low = lo;
        w.interval_high = hi;
        return w;
    endfunction

    task automatic test_directed;
        send_word(make_word(CMD_EVAL, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_ADD, 63, 15, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_word(make_word(CMD_ADD, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
        send_word(make_word(CMD_ADD, 0, 0, 0, -10, 10));
        send_word(make_word(CMD_ADD, 0, 0, 0, 100, 100));
        send_word(make_word(CMD_ADD, 0, 0, 0, 200, 300));
        send_word(make_word(CMD_ADD, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_ADD, 0, 1, 0, 32'h8000_0000, -1));
        send_word(make_word(CMD_EVENT, 0, 0, 32'h7FFF_FFFF, 0, 0));
        send_word(make_word(CMD_EVENT, 0, 15, 32'h8000_0000, 0, 0));
        send_word(make_word(CMD_EVENT, 0, 1, -5, 0, 0));
        send_word(make_word(CMD_EVAL, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_EVENT, 63, 0, -10, 0, 0));
        send_word(make_word(CMD_EVENT, 0, 0, 500, 0, 0));
        send_word(make_word(CMD_EVENT, 0, 1, 32'h8000_0000, 0, 0));
        send_word(make_word(CMD_EVENT, 0, 15, 32'hFFFF_FFFF, 0, 0));
        send_word(make_word(CMD_EVAL, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_CLEAR, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_CLEAR, 63, 15, 0, 0, 0));
        send_word(make_word(CMD_EVENT, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_EVAL, 0, 0, 0, 0, 0));
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(40) - 20;
        endcase
    endfunction

    task automatic test_random;
        t_in_word    w;
        logic [31:0] a;
        logic [31:0] b;
        for (int n = 0; n < 420; n++) begin
            idle_on = !(n >= 150 && n < 230);
            w = make_word(2'($urandom_range(3)), $urandom_range(NSUB - 1),
                          $urandom_range(NATTR - 1), pick_value(), 0, 0);
            case ($urandom_range(9))
                0, 1, 2: begin
                    w.command = CMD_ADD;
                    w.subscription_index = 6'($urandom_range(7) * 9);
                    w.attribute_id = 4'($urandom_range(3) * 5);
                    a = pick_value();
                    b = pick_value();
                    if ($urandom_range(9) == 0 || $signed(a) <= $signed(b)) begin
                        w.interval_low = a;
                        w.interval_high = b;
                    end else begin
                        w.interval_low = b;
                        w.interval_high = a;
                    end
                end
                3: w.command = CMD_CLEAR;
                4, 5, 6, 7: begin
                    w.command = CMD_EVENT;
                    if ($urandom_range(3) != 0) w.attribute_id = 4'($urandom_range(3) * 5);
                end
                8: w.command = CMD_EVAL;
                default: begin
                end
            endcase
            send_word(w);
        end
        send_word(make_word(CMD_EVAL, 0, 0, 0, 0, 0));
    endtask

    initial begin
        for (int s = 0; s < NSUB; s++)
            for (int a = 0; a < NATTR; a++) sub_count[s][a] = 0;
        for (int a = 0; a < NATTR; a++) ev_have[a] = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("tb_top: errors");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/sim_pkg.sv
hw/rtl/sim_datapath.sv
hw/rtl/sim_ctrl.sv
hw/rtl/subscription_interval_matcher.sv
bench/tb_top.sv
